/* sv/hrc_pkg.sv */
package hrc_pkg;

	localparam int DEPTH       = 64;
	localparam int ENTRY_WIDTH = 32;
	localparam int SLOT_W      = $clog2(DEPTH);
	localparam int SIZE_W      = $clog2(DEPTH + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_NEXT   = 3'd1,
		CMD_PREV   = 3'd2,
		CMD_SEEK   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [0:0] {
		REG_RING_SIZE = 1'b0
	} reg_idx_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [ENTRY_WIDTH-1:0] entry_value;
	} in_word_t;

	typedef struct packed {
		logic                   found;
		logic [ENTRY_WIDTH-1:0] entry_out;
	} out_word_t;

endpackage

/* sv/history_ring_with_cursor_core.sv */
// An accepted word is registered in stage s1; its result word is registered in s2.
// One word per cycle while out_stall is low; the store is one array with a single write
// port at the end slot and one registered read port.
// Reset clears all pointers and counts (ring empty, cursor at the end) and sets
// ring_size to 64; the entry store is not cleared.
module history_ring_with_cursor_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  hrc_pkg::in_word_t            in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output hrc_pkg::out_word_t           out_word,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hrc_pkg::PADDR_W-1:0]  paddr,
	input  logic [hrc_pkg::PDATA_W-1:0]  pwdata,
	output logic [hrc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import hrc_pkg::*;

	logic [ENTRY_WIDTH-1:0] mem [DEPTH];

	logic                   valid_s1;
	in_word_t               word_s1;
	logic                   valid_s2;
	logic                   found_s2;
	logic [ENTRY_WIDTH-1:0] rd_data_s2;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] filled_q;
	logic [SLOT_W-1:0] oldest_q;
	logic              oldest_valid_q;
	logic [SLOT_W-1:0] end_q;
	logic [SLOT_W-1:0] cursor_q;
	logic              at_end_q;

	logic [SIZE_W-1:0] filled_d;
	logic [SLOT_W-1:0] oldest_d;
	logic              oldest_valid_d;
	logic [SLOT_W-1:0] end_d;
	logic [SLOT_W-1:0] cursor_d;
	logic              at_end_d;
	logic              found_d;
	logic [SLOT_W-1:0] rd_addr;
	logic              mem_we;

	logic              adv_s2;
	logic              upd;
	logic              cfg_we;
	logic [SIZE_W-1:0] wr_size;
	logic [SIZE_W-1:0] clamped;
	logic [SLOT_W-1:0] end_up;
	logic [SLOT_W-1:0] oldest_up;
	logic [SLOT_W-1:0] cursor_up;
	logic [SLOT_W-1:0] cursor_dn;

	function automatic logic [SLOT_W-1:0] step_up(input logic [SLOT_W-1:0] s,
			input logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] inc;
		inc = {1'b0, s} + SIZE_W'(1);
		return (inc >= sz) ? '0 : inc[SLOT_W-1:0];
	endfunction

	assign adv_s2   = !valid_s2 || !out_stall;
	assign upd      = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && (reg_idx_t'(paddr[2]) == REG_RING_SIZE);
	assign wr_size = pwdata[SIZE_W-1:0];
	assign clamped = (wr_size == '0) ? SIZE_W'(1) :
		(wr_size > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : wr_size;
	assign prdata  = (reg_idx_t'(paddr[2]) == REG_RING_SIZE) ?
		PDATA_W'(size_q) : '0;

	assign end_up    = step_up(end_q, size_q);
	assign oldest_up = step_up(oldest_q, size_q);
	assign cursor_up = step_up(cursor_q, size_q);
	assign cursor_dn = (cursor_q == '0) ? SLOT_W'(size_q - SIZE_W'(1)) :
		cursor_q - SLOT_W'(1);

	always_comb begin
		filled_d       = filled_q;
		oldest_d       = oldest_q;
		oldest_valid_d = oldest_valid_q;
		end_d          = end_q;
		cursor_d       = cursor_q;
		at_end_d       = at_end_q;
		found_d        = 1'b0;
		rd_addr        = cursor_q;
		mem_we         = 1'b0;
		case (word_s1.cmd)
			CMD_APPEND: begin
				mem_we = upd;
				if (filled_q < size_q) begin
					filled_d = filled_q + SIZE_W'(1);
					if (!oldest_valid_q) begin
						oldest_d       = '0;
						oldest_valid_d = 1'b1;
					end
				end else begin
					oldest_d = oldest_up;
				end
				end_d    = end_up;
				cursor_d = end_up;
				at_end_d = 1'b1;
			end
			CMD_NEXT: begin
				rd_addr = cursor_up;
				if (at_end_q || cursor_up == end_q) begin
					cursor_d = end_q;
					at_end_d = 1'b1;
				end else begin
					cursor_d = cursor_up;
					at_end_d = 1'b0;
					found_d  = 1'b1;
				end
			end
			CMD_PREV: begin
				if (oldest_valid_q && cursor_q == oldest_q && !at_end_q) begin
					found_d = 1'b1;
					rd_addr = oldest_q;
				end else if (oldest_valid_q) begin
					cursor_d = cursor_dn;
					at_end_d = 1'b0;
					found_d  = 1'b1;
					rd_addr  = cursor_dn;
				end
			end
			CMD_SEEK: begin
				cursor_d = end_q;
				at_end_d = 1'b1;
			end
			CMD_CLEAR: begin
				filled_d       = '0;
				oldest_d       = '0;
				oldest_valid_d = 1'b0;
				end_d          = '0;
				cursor_d       = '0;
				at_end_d       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			found_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				found_s2 <= valid_s1 && found_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q         <= SIZE_W'(DEPTH);
			filled_q       <= '0;
			oldest_q       <= '0;
			oldest_valid_q <= 1'b0;
			end_q          <= '0;
			cursor_q       <= '0;
			at_end_q       <= 1'b1;
		end else if (cfg_we) begin
			size_q         <= clamped;
			filled_q       <= '0;
			oldest_q       <= '0;
			oldest_valid_q <= 1'b0;
			end_q          <= '0;
			cursor_q       <= '0;
			at_end_q       <= 1'b1;
		end else if (upd) begin
			filled_q       <= filled_d;
			oldest_q       <= oldest_d;
			oldest_valid_q <= oldest_valid_d;
			end_q          <= end_d;
			cursor_q       <= cursor_d;
			at_end_q       <= at_end_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[end_q] <= word_s1.entry_value;
		end
		if (adv_s2) begin
			rd_data_s2 <= mem[rd_addr];
		end
	end

	assign out_valid          = valid_s2;
	assign out_word.found     = found_s2;
	assign out_word.entry_out = found_s2 ? rd_data_s2 : '0;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= size_q)
		else $error("fill count above ring size");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, end_q} < size_q && {1'b0, cursor_q} < size_q && {1'b0, oldest_q} < size_q)
		else $error("slot pointer outside ring");

	a_append_end: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !cfg_we && word_s1.cmd == CMD_APPEND |=> at_end_q && cursor_q == end_q)
		else $error("cursor not at end after append");

	a_empty_state: assert property (@(posedge clk) disable iff (!arst_n)
		!oldest_valid_q |-> filled_q == '0 && at_end_q)
		else $error("empty ring with entries or cursor off end");

	a_found_needs_entries: assert property (@(posedge clk) disable iff (!arst_n)
		upd && found_d |-> oldest_valid_q)
		else $error("entry returned from empty ring");
`endif

endmodule
